// ----- hw/rtl/llga_pkg.sv -----
// ----------------------------------------------------------------------------
// llga_pkg
// shared widths, codes and controller/datapath interface types for the
// logistic loss gradient accumulator
// ----------------------------------------------------------------------------
package llga_pkg;

    localparam int FUNC_W     = 2;
    localparam int ANN_W      = 2;
    localparam int PRED_W     = 17;
    localparam int IDX_W      = 12;
    localparam int FVAL_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int GRAD_W     = 40;
    localparam int LOSS_W     = 48;
    localparam int N_W        = 4;
    localparam int FRAC_W     = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 96;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACC        = 2'd0,
        FUNC_READ_CLEAR = 2'd1,
        FUNC_CLEAR_LOSS = 2'd2,
        FUNC_NOP        = 2'd3
    } func_t;

    localparam logic [ANN_W-1:0]    ANN_NONE     = 2'b00;
    localparam logic [ANN_W-1:0]    ANN_POS      = 2'b01;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
    localparam logic [PRED_W-1:0]   PROB_ONE     = 17'd65536;
    localparam logic signed [32:0]  LN2_Q32      = 33'sd2977044472;
    localparam logic [3:0]          LOG_LAST_BIT = 4'd15;

    typedef struct packed {
        logic clr_we;
        logic cap_in;
        logic rd_en;
        logic mul1;
        logic mul2;
        logic gupd;
        logic log_init;
        logic log_step;
        logic log_mul;
        logic loss_mul;
        logic loss_add;
        logic out_load;
    } llga_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic need_log;
        logic log_last;
    } llga_stat_t;

endpackage

// ----- hw/rtl/llga_ram.sv -----
// ----------------------------------------------------------------------------
// llga_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module llga_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/llga_dp.sv -----
// ----------------------------------------------------------------------------
// llga_dp
// datapath: request capture, gradient read-modify-write, iterative log unit,
// loss accumulation and output register
// ----------------------------------------------------------------------------
module llga_dp
    import llga_pkg::*;
#(
    parameter int GRADIENT_DEPTH = 4096,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  llga_cmd_t            cmd,
    output llga_stat_t           stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]    s_tuser,
    input  logic                 s_tlast,
    input  logic                 cfg_we,
    input  logic [WEIGHT_W-1:0]  cfg_data,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam bit FULL_RANGE = GRADIENT_DEPTH >= (1 << IDX_W);
    localparam int MEM_DEPTH  = FULL_RANGE ? (1 << IDX_W) : GRADIENT_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int LI_W       = LOG_TABLE_BITS + 1;
    localparam logic signed [20:0] L2_OFFSET = 21'(LOG_TABLE_BITS * 65536);

    // captured request
    logic [FUNC_W-1:0]        func_reg;
    logic [ANN_W-1:0]         ann_reg;
    logic                     hasf_reg;
    logic [PRED_W-1:0]        p_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [FVAL_W-1:0] x_reg;
    logic                     last_reg;

    logic [WEIGHT_W-1:0]      loss_weight_reg;
    logic [LOSS_W-1:0]        loss_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;

    logic [GRAD_W-1:0]        gold_reg;
    logic [31:0]              wc_reg;
    logic signed [47:0]       gprod_reg;
    logic [GRAD_W-1:0]        gout_reg;
    logic                     clip_reg;

    logic [N_W-1:0]           n_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic [30:0]              m_reg;
    logic [3:0]               k_reg;
    logic signed [53:0]       lnprod_reg;
    logic signed [38:0]       lp_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    logic [PRED_W-1:0] pred_in;
    logic [PRED_W-1:0] pred_sat;
    logic              pos;
    logic              active;
    logic              in_range;
    logic [PRED_W-1:0] coef;
    logic [PRED_W-1:0] q;

    // ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [GRAD_W-1:0] ram_wdata;
    logic [GRAD_W-1:0] ram_rdata;

    // gradient update
    logic [32:0]        wc_next;
    logic signed [48:0] gprod_next;
    logic [48:0]        grnd;
    logic [32:0]        gdelta;
    logic [33:0]        gdelta_s;
    logic [40:0]        gsum;
    logic               govf;
    logic [GRAD_W-1:0]  gsat;
    logic               gwrite;
    logic [GRAD_W-1:0]  gwdata;
    logic [GRAD_W-1:0]  gout_next;

    // log unit
    logic [PRED_W-1:0]  qsh;
    logic [LI_W-1:0]    li;
    logic [LI_W-1:0]    li0;
    logic [N_W-1:0]     n_init;
    logic [30:0]        m_init;
    logic [61:0]        sq_full;
    logic [31:0]        sq;
    logic signed [20:0] l2;
    logic signed [53:0] lnprod_next;
    logic signed [53:0] lnrnd;
    logic signed [21:0] le;
    logic signed [38:0] lp_next;
    logic [38:0]        lprnd;
    logic [30:0]        ld;
    logic [48:0]        lsum;
    logic               lovf;
    logic [LOSS_W-1:0]  lsat;

    assign pred_in  = s_tdata[19:3];
    assign pred_sat = (pred_in > PROB_ONE) ? PROB_ONE : pred_in;

    assign pos      = ann_reg == ANN_POS;
    assign active   = (func_reg == FUNC_ACC) && (ann_reg != ANN_NONE) && hasf_reg;
    assign in_range = FULL_RANGE || (idx_reg < IDX_W'(GRADIENT_DEPTH));
    assign coef     = pos ? (PROB_ONE - p_reg) : p_reg;
    assign q        = pos ? p_reg : (PROB_ONE - p_reg);

    // gradient term and saturating update
    always_comb begin
        wc_next    = {17'b0, loss_weight_reg} * {16'b0, coef};
        gprod_next = $signed({1'b0, wc_reg}) * x_reg;
        grnd       = {gprod_reg[47], gprod_reg} + 49'd32768;
        gdelta     = grnd[48:16];
        gdelta_s   = pos ? {gdelta[32], gdelta} : (34'd0 - {gdelta[32], gdelta});
        gsum       = {gold_reg[GRAD_W-1], gold_reg} + {{7{gdelta_s[33]}}, gdelta_s};
        govf       = gsum[40] != gsum[39];
        if (!govf) begin
            gsat = gsum[GRAD_W-1:0];
        end else if (gsum[40]) begin
            gsat = {1'b1, {(GRAD_W-1){1'b0}}};
        end else begin
            gsat = {1'b0, {(GRAD_W-1){1'b1}}};
        end
        gwrite    = 1'b0;
        gwdata    = '0;
        gout_next = '0;
        if (in_range) begin
            if (active) begin
                gwrite    = 1'b1;
                gwdata    = gsat;
                gout_next = gsat;
            end else if (func_reg == FUNC_ACC) begin
                gout_next = gold_reg;
            end else if (func_reg == FUNC_READ_CLEAR) begin
                gwrite    = 1'b1;
                gout_next = gold_reg;
            end
        end
    end

    // log2 by repeated squaring, then scaling by ln 2
    always_comb begin
        qsh    = q >> (16 - LOG_TABLE_BITS);
        li     = qsh[LI_W-1:0];
        li0    = (li == '0) ? LI_W'(1) : li;
        n_init = '0;
        for (int b = 0; b < LI_W; b++) begin
            if (li0[b]) begin
                n_init = N_W'(b);
            end
        end
        m_init      = 31'(li0) << (30 - int'(n_init));
        sq_full     = {31'b0, m_reg} * {31'b0, m_reg};
        sq          = sq_full[61:30];
        l2          = $signed({1'b0, n_reg, frac_reg}) - L2_OFFSET;
        lnprod_next = l2 * LN2_Q32;
        lnrnd       = lnprod_reg + 54'sd2147483648;
        le          = lnrnd[53:32];
        lp_next     = $signed({1'b0, loss_weight_reg}) * le;
        lprnd       = lp_reg + 39'sd128;
        ld          = lprnd[38:8];
        lsum        = {loss_reg[LOSS_W-1], loss_reg} + {{18{ld[30]}}, ld};
        lovf        = lsum[48] != lsum[47];
        if (!lovf) begin
            lsat = lsum[LOSS_W-1:0];
        end else if (lsum[48]) begin
            lsat = {1'b1, {(LOSS_W-1){1'b0}}};
        end else begin
            lsat = {1'b0, {(LOSS_W-1){1'b1}}};
        end
    end

    assign ram_we    = cmd.clr_we || (cmd.gupd && gwrite);
    assign ram_waddr = cmd.clr_we ? clr_addr_reg : idx_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.clr_we ? '0 : gwdata;

    llga_ram #(
        .WIDTH (GRAD_W),
        .DEPTH (MEM_DEPTH)
    ) u_grad_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // control-like state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_weight_reg <= WEIGHT_RESET;
            loss_reg        <= '0;
            clr_addr_reg    <= '0;
        end else begin
            if (cfg_we) begin
                loss_weight_reg <= cfg_data;
            end
            if (cmd.clr_we) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.gupd && (func_reg == FUNC_CLEAR_LOSS)) begin
                loss_reg <= '0;
            end else if (cmd.loss_add) begin
                loss_reg <= lsat;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            func_reg <= s_tuser;
            ann_reg  <= s_tdata[1:0];
            hasf_reg <= s_tdata[2];
            p_reg    <= pred_sat;
            idx_reg  <= s_tdata[31:20];
            x_reg    <= $signed(s_tdata[47:32]);
            last_reg <= s_tlast;
        end
        if (cmd.mul1) begin
            gold_reg <= ram_rdata;
            wc_reg   <= wc_next[31:0];
        end
        if (cmd.mul2) begin
            gprod_reg <= gprod_next[47:0];
        end
        if (cmd.gupd) begin
            gout_reg <= gout_next;
            clip_reg <= active && in_range && govf;
        end else if (cmd.loss_add) begin
            clip_reg <= clip_reg || lovf;
        end
        if (cmd.log_init) begin
            n_reg    <= n_init;
            m_reg    <= m_init;
            frac_reg <= '0;
            k_reg    <= LOG_LAST_BIT;
        end else if (cmd.log_step) begin
            if (sq[31]) begin
                frac_reg[k_reg] <= 1'b1;
                m_reg           <= sq[31:1];
            end else begin
                m_reg <= sq[30:0];
            end
            k_reg <= k_reg - 4'd1;
        end
        if (cmd.log_mul) begin
            lnprod_reg <= lnprod_next;
        end
        if (cmd.loss_mul) begin
            lp_reg <= lp_next;
        end
        if (cmd.out_load) begin
            m_data_reg <= {7'b0, clip_reg, loss_reg, gout_reg};
        end
    end

    assign stat.clr_done = clr_addr_reg == ADDR_W'(MEM_DEPTH - 1);
    assign stat.need_log = active && last_reg;
    assign stat.log_last = k_reg == 4'd0;
    assign m_tdata       = m_data_reg;

endmodule

// ----- hw/rtl/llga_ctrl.sv -----
// ----------------------------------------------------------------------------
// llga_ctrl
// controller: clearing sweep, per-request sequencing and output valid
// ----------------------------------------------------------------------------
module llga_ctrl
    import llga_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  llga_stat_t stat,
    output llga_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_GUPD,
        ST_LOGN,
        ST_LOGSQ,
        ST_LOGMUL,
        ST_LOSSMUL,
        ST_LOSSADD,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_GUPD;
            end
            ST_GUPD: begin
                cmd.gupd   = 1'b1;
                state_next = stat.need_log ? ST_LOGN : ST_OUT;
            end
            ST_LOGN: begin
                cmd.log_init = 1'b1;
                state_next   = ST_LOGSQ;
            end
            ST_LOGSQ: begin
                cmd.log_step = 1'b1;
                if (stat.log_last) begin
                    state_next = ST_LOGMUL;
                end
            end
            ST_LOGMUL: begin
                cmd.log_mul = 1'b1;
                state_next  = ST_LOSSMUL;
            end
            ST_LOSSMUL: begin
                cmd.loss_mul = 1'b1;
                state_next   = ST_LOSSADD;
            end
            ST_LOSSADD: begin
                cmd.loss_add = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- hw/rtl/logistic_loss_gradient_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// logistic_loss_gradient_accumulator_unit
// streaming accumulator for the gradient and value of a weighted logistic
// log likelihood, one nonzero feature element per request
// ----------------------------------------------------------------------------
// After reset the gradient ram is swept to zero, one entry per cycle, for
// min(GRADIENT_DEPTH, 4096) entries; s_tready stays low during the sweep,
// while loss_weight writes are taken as ever. Each request then runs through
// a read-modify-write of its gradient entry (read, two multiply steps and
// the update) before its result is loaded; when it closes an annotated
// instance that has features, the log unit then squares a mantissa once per
// cycle for 16 fraction bits before the loss multiply and loss add. A new
// request is accepted once the previous one has its result in the output
// register, even if that result is still waiting for m_tready, so the block
// works on one request at a time; a result is only loaded once the one
// before it has been taken.
module logistic_loss_gradient_accumulator_unit
    import llga_pkg::*;
#(
    parameter int GRADIENT_DEPTH = 4096,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // annotation [1:0], has_features [2], prediction [19:3],
    // feature_index [31:20], feature_value [47:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [FUNC_W-1:0]    s_tuser,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // gradient_value [39:0], loss_total [87:40], saturated [88], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WEIGHT_W-1:0]  cfg_data
);

    llga_cmd_t  cmd;
    llga_stat_t stat;

    assign cfg_ready = 1'b1;

    llga_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    llga_dp #(
        .GRADIENT_DEPTH (GRADIENT_DEPTH),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- hw/rtl/llga_checker.sv -----
// ----------------------------------------------------------------------------
// llga_checker
// port-level checks: one result per request, bounded requests in flight,
// output held while stalled
// ----------------------------------------------------------------------------
module llga_checker
    import llga_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg + {2'b0, s_acc} - {2'b0, m_acc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // no result without a request behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pending_reg != 3'd0))
        else $error("result offered with no request in flight");

    // at most one request at work and one result waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd2)
        else $error("more requests in flight than the block can hold");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind logistic_loss_gradient_accumulator_unit llga_checker u_llga_checker (.*);
